[rtl/pick_without_replacement_pool_top_assert.svh]
// Assertion macros shared by the pick-without-replacement pool RTL.
// No dependencies; defining NO_ASSERTIONS turns every macro into nothing.
`ifndef PICK_WITHOUT_REPLACEMENT_POOL_TOP_ASSERT_SVH
`define PICK_WITHOUT_REPLACEMENT_POOL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every clock edge outside reset.
`define PWRP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never occurs outside reset.
`define PWRP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PWRP_ASSERT(label, clk, rst, prop, msg)
`define PWRP_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[rtl/pwrp_pkg.sv]
// Shared types and constants of the pick-without-replacement pool.
// No dependencies; imported by the remainder unit, the top level and the testbench.
package pwrp_pkg;

   // The item and count fields below are sized for this store depth, so the
   // depth is fixed here rather than left open as a module parameter.
   localparam int POOL_DEPTH         = 64;
   localparam int ITEM_W             = 6;
   localparam int CFG_W              = 7;
   localparam int REMAIN_W           = 7;
   localparam int RND_W              = 32;
   localparam int STATUS_W           = 2;
   localparam int OP_W               = 3;

   localparam logic [CFG_W-1:0] POOL_SIZE_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_FILL    = 3'd0;
   localparam logic [OP_W-1:0] OP_RESTORE = 3'd1;
   localparam logic [OP_W-1:0] OP_POS     = 3'd2;
   localparam logic [OP_W-1:0] OP_RANDOM  = 3'd3;
   localparam logic [OP_W-1:0] OP_VALUE   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [5:0]        position;
      logic [RND_W-1:0]  random_word;
      logic [ITEM_W-1:0] wanted_item;
   } req_type;

   typedef struct packed {
      logic [ITEM_W-1:0]   picked_item;
      logic [STATUS_W-1:0] status;
      logic [REMAIN_W-1:0] remaining_after;
   } rsp_type;

endpackage

[rtl/pwrp_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pwrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pwrp_mod_unit.sv]
// Bit-serial remainder unit: random word modulo the remaining count.
// Depends on pwrp_pkg for the random word width.
module pwrp_mod_unit
   import pwrp_pkg::*;
#(
   parameter int COUNT_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RND_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [COUNT_W-1:0] remainder
);

   localparam int BIT_CNT_W = $clog2(RND_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [RND_W-1:0]     shift_ff, shift_in;
   logic [COUNT_W-1:0]   div_ff, div_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W:0]     trial;

   // One quotient bit per cycle: shift in the next dividend bit and
   // subtract the divisor when the partial remainder reaches it.
   assign trial = {rem_ff, shift_ff[RND_W-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         bit_in   = '0;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[RND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[COUNT_W-1:0];
         end
         bit_in = bit_ff + BIT_CNT_W'(1);
         if (bit_ff == BIT_CNT_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bit_ff  <= bit_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/pick_without_replacement_pool_top.sv]
// Top level of the pick-without-replacement pool: control sequencer and ports.
// Depends on pwrp_pkg, pwrp_ram, pwrp_mod_unit and the assertion macro header.
//
// The pool keeps a permutation of item numbers in one RAM of POOL_DEPTH
// entries; the items still in the pool sit at positions below the remaining
// count. A pick reads the chosen entry and the last remaining entry, swaps
// them and decrements the count, so every item leaves at most once until a
// fill or restore. Transactions are handled one at a time. Restore, undefined
// codes and failed position or empty random picks go straight to the result
// register; a position pick reads the chosen and the last entry and then
// writes them back swapped (two reads and two writes on the single RAM port
// pair); a random pick first runs the bit-serial remainder of the 32-bit
// random word; a value pick scans the remaining entries at one RAM read per
// cycle and stops at the first match, or reports a miss once it has passed
// the remaining count. Fill rewrites every RAM entry, one per cycle. After
// reset the same identity pass runs with req_ready low and no result; csr
// writes are taken at any time, but are meant for an idle block. A new
// request is accepted while a finished result still waits in the response
// register.
`include "pick_without_replacement_pool_top_assert.svh"

module pick_without_replacement_pool_top
   import pwrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SWEEP   = 9'b000000010,
      S_DIV     = 9'b000000100,
      S_SEARCH  = 9'b000001000,
      S_RD_SLOT = 9'b000010000,
      S_RD_LAST = 9'b000100000,
      S_WR_SLOT = 9'b001000000,
      S_WR_LAST = 9'b010000000,
      S_RESULT  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  pool_size_ff, pool_size_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              report_ff, report_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [AW-1:0]     item_ff, item_in;
   logic [ITEM_W-1:0] want_ff, want_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic          accept;
   logic [CW-1:0] fill_cnt;
   logic [AW-1:0] last_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] mem_rdata;
   logic          mod_start;
   logic          mod_done;
   logic [CW-1:0] mod_rem;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // Fill and restore never put more items in the pool than the store holds.
   assign fill_cnt  = (32'(pool_size_ff) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                            : CW'(pool_size_ff);
   assign last_addr = AW'(count_ff - CW'(1));
   assign mod_start = accept && (req_data.operation == OP_RANDOM) && (count_ff != '0);

   pwrp_ram #(
      .WIDTH (AW),
      .DEPTH (POOL_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pwrp_mod_unit #(
      .COUNT_W (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_data.random_word),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Sequencer. Only one transaction is in flight, and its RAM writes finish
   // before the next transaction can issue a read, so no forwarding is needed.
   always_comb begin
      state_in     = state_ff;
      pool_size_in = pool_size_ff;
      count_in     = count_ff;
      sweep_in     = sweep_ff;
      report_in    = report_ff;
      slot_in      = slot_ff;
      item_in      = item_ff;
      want_in      = want_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      rd_idx_in    = rd_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = item_ff;
      mem_raddr    = slot_ff;

      if (csr_valid && csr_ready) begin
         pool_size_in = csr_data;
      end

      // The response register frees itself as soon as the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               want_in = req_data.wanted_item;
               res_in  = '{picked_item: '0, status: ST_OK,
                           remaining_after: REMAIN_W'(count_ff)};
               unique case (req_data.operation)
                  OP_FILL: begin
                     count_in  = fill_cnt;
                     report_in = 1'b1;
                     res_in.remaining_after = REMAIN_W'(fill_cnt);
                     state_in  = S_SWEEP;
                  end
                  OP_RESTORE: begin
                     count_in = fill_cnt;
                     res_in.remaining_after = REMAIN_W'(fill_cnt);
                     state_in = S_RESULT;
                  end
                  OP_POS: begin
                     if (32'(req_data.position) < 32'(count_ff)) begin
                        slot_in  = AW'(req_data.position);
                        state_in = S_RD_SLOT;
                     end else begin
                        res_in.status = ST_MISS;
                        state_in      = S_RESULT;
                     end
                  end
                  OP_RANDOM: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  OP_VALUE: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end

         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = sweep_ff;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == AW'(POOL_DEPTH - 1)) begin
               sweep_in = '0;
               state_in = report_ff ? S_RESULT : S_IDLE;
            end
         end

         S_DIV: begin
            if (mod_done) begin
               slot_in  = AW'(mod_rem);
               state_in = S_RD_SLOT;
            end
         end

         // Pipelined scan: the entry read in the previous cycle is compared
         // while the next one is being read.
         S_SEARCH: begin
            mem_raddr = AW'(scan_ff);
            if (pend_ff && (32'(mem_rdata) == 32'(want_ff))) begin
               slot_in  = rd_idx_ff;
               state_in = S_RD_SLOT;
            end else if (scan_ff < count_ff) begin
               pend_in   = 1'b1;
               rd_idx_in = AW'(scan_ff);
               scan_in   = scan_ff + CW'(1);
            end else begin
               res_in.status = ST_MISS;
               state_in      = S_RESULT;
            end
         end

         S_RD_SLOT: begin
            mem_raddr = slot_ff;
            state_in  = S_RD_LAST;
         end

         S_RD_LAST: begin
            mem_raddr = last_addr;
            item_in   = mem_rdata;
            state_in  = S_WR_SLOT;
         end

         S_WR_SLOT: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            mem_wdata = mem_rdata;
            state_in  = S_WR_LAST;
         end

         S_WR_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = last_addr;
            mem_wdata = item_ff;
            count_in  = count_ff - CW'(1);
            res_in    = '{picked_item: ITEM_W'(item_ff), status: ST_OK,
                          remaining_after: REMAIN_W'(count_ff - CW'(1))};
            state_in  = S_RESULT;
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         pool_size_ff <= POOL_SIZE_RESET;
         count_ff     <= (32'(POOL_SIZE_RESET) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                                  : CW'(POOL_SIZE_RESET);
         sweep_ff     <= '0;
         report_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         report_ff    <= report_in;
         pend_ff      <= pend_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff     <= slot_in;
      item_ff     <= item_in;
      want_ff     <= want_in;
      rd_idx_ff   <= rd_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PWRP_ASSERT(a_count_in_range, clock, reset, 32'(count_ff) <= 32'(POOL_DEPTH), "remaining count exceeds the store depth")
   `PWRP_ASSERT(a_fail_no_item, clock, reset, (rsp_valid_ff && (rsp_data_ff.status != ST_OK)) |-> (rsp_data_ff.picked_item == '0), "failed transaction returned an item")
   `PWRP_ASSERT(a_empty_means_zero, clock, reset, (rsp_valid_ff && (rsp_data_ff.status == ST_EMPTY)) |-> (rsp_data_ff.remaining_after == '0), "empty status with items left")
   `PWRP_ASSERT_NEVER(a_write_in_idle, clock, reset, mem_we && ((state_ff == S_IDLE) || (state_ff == S_SEARCH) || (state_ff == S_RESULT)), "store written outside a write step")
   `PWRP_ASSERT(a_accept_leaves_idle, clock, reset, accept |=> (state_ff != S_IDLE), "accepted transaction did not start")

endmodule

[tb/tb_pick_without_replacement_pool_top.sv]
// Self-checking testbench of the pick-without-replacement pool top level.
// Depends on pwrp_pkg and pick_without_replacement_pool_top; checks every
// response against a built-in model of the permutation store or, for typed rows, a hand-written expectation.
`timescale 1ns / 100ps

module tb_pick_without_replacement_pool_top;
   import pwrp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RESET_CYCLES = 11;
   // The slowest transaction is a value pick that matches the last entry; the settle time covers it.
   localparam int SETTLE_CYCLES = POOL_DEPTH + 16;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_SHOWN     = 10;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 85;

   // Operation codes that the block does not define; it must ignore them.
   localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // One row of the directed table: either a pool_size write or a request.
   // Rows marked typed carry an expected response that is obvious by hand;
   // all other rows take their expectation from the pool model below.
   typedef struct {
      row_kind_type     kind;
      logic [CFG_W-1:0] cfg_value;
      req_type          item;
      logic             typed;
      rsp_type          rsp;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   // Model state: the permutation store, the count of items left in the pool
   // and the pool_size register as the block should hold them.
   logic [ITEM_W-1:0]   pool_items [POOL_DEPTH];
   logic [REMAIN_W-1:0] left_count;
   logic [CFG_W-1:0]    pool_cfg;

   rsp_type      expected_rsp [$];
   plan_row_type plan [$];
   int unsigned  error_count = 0;
   int unsigned  rsp_seen    = 0;
   int unsigned  cycle_count = 0;
   // Raised by the stimulus side to ask the receiver for one long hold-off.
   logic         rsp_hold_asked = 1'b0;

   pick_without_replacement_pool_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Pool model
   // ------------------------------------------------------------------

   // Fill and restore never put more items in the pool than the store holds.
   function automatic logic [REMAIN_W-1:0] fill_level();
      return (pool_cfg > POOL_DEPTH) ? REMAIN_W'(POOL_DEPTH) : REMAIN_W'(pool_cfg);
   endfunction

   // Removes the item at a slot below the count: it trades places with the
   // last item still in the pool, and the count drops by one.
   function automatic logic [ITEM_W-1:0] take_entry(input int unsigned slot);
      logic [ITEM_W-1:0] taken;
      int unsigned       last;
      taken = pool_items[slot];
      last = left_count - 1;
      pool_items[slot] = pool_items[last];
      pool_items[last] = taken;
      left_count = REMAIN_W'(last);
      return taken;
   endfunction

   function automatic rsp_type pool_predict(input req_type item);
      rsp_type     res;
      int unsigned idx;
      logic        hit;
      res = '0;
      res.status = ST_OK;
      hit = 1'b0;
      case (item.operation)
         OP_FILL: begin
            for (idx = 0; idx < POOL_DEPTH; idx++) pool_items[idx] = ITEM_W'(idx);
            left_count = fill_level();
         end
         OP_RESTORE: begin
            left_count = fill_level();
         end
         OP_POS: begin
            // An empty pool falls in here too, since no position is below zero.
            if (item.position < left_count) res.picked_item = take_entry(item.position);
            else res.status = ST_MISS;
         end
         OP_RANDOM: begin
            if (left_count == 0) res.status = ST_EMPTY;
            else res.picked_item = take_entry(item.random_word % left_count);
         end
         OP_VALUE: begin
            // Only items still in the pool are searched; the first match wins.
            for (idx = 0; idx < left_count && !hit; idx++) begin
               if (pool_items[idx] == item.wanted_item) begin
                  res.picked_item = take_entry(idx);
                  hit = 1'b1;
               end
            end
            if (!hit) res.status = ST_MISS;
         end
         default: ;
      endcase
      res.remaining_after = left_count;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic plan_row_type req_row(input logic [OP_W-1:0] op, input logic [5:0] pos,
                                            input logic [RND_W-1:0] rnd,
                                            input logic [ITEM_W-1:0] want, input logic typed,
                                            input logic [ITEM_W-1:0] exp_item,
                                            input logic [STATUS_W-1:0] exp_status,
                                            input logic [REMAIN_W-1:0] exp_left);
      plan_row_type row;
      row.kind = ROW_REQ;
      row.cfg_value = '0;
      row.item.operation = op;
      row.item.position = pos;
      row.item.random_word = rnd;
      row.item.wanted_item = want;
      row.typed = typed;
      row.rsp.picked_item = exp_item;
      row.rsp.status = exp_status;
      row.rsp.remaining_after = exp_left;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CFG_W-1:0] value);
      plan_row_type row;
      row = req_row(OP_RESTORE, '0, '0, '0, 1'b0, '0, ST_OK, '0);
      row.kind = ROW_CSR;
      row.cfg_value = value;
      return row;
   endfunction

   // Random requests are mostly well formed: positions and wanted items are
   // drawn from what is still in the pool, and an empty pool is usually
   // refilled. The rest is out-of-range noise and spare operation codes.
   function automatic req_type next_request();
      req_type     item;
      int unsigned roll;
      item.position = 6'($urandom_range(0, 63));
      item.random_word = $urandom;
      item.wanted_item = ITEM_W'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (left_count == 0 && $urandom_range(0, 3) != 0) roll = $urandom_range(0, 11);
      if (roll < 4) item.operation = OP_FILL;
      else if (roll < 12) item.operation = OP_RESTORE;
      else if (roll < 40) item.operation = OP_POS;
      else if (roll < 65) item.operation = OP_RANDOM;
      else if (roll < 97) item.operation = OP_VALUE;
      else item.operation = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (left_count != 0 && $urandom_range(0, 4) != 0) begin
         item.position = 6'($urandom_range(0, left_count - 1));
         item.wanted_item = pool_items[$urandom_range(0, left_count - 1)];
      end
      return item;
   endfunction

   task automatic log_error(input string what);
      error_count++;
      if (error_count <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, what);
   endtask

   // Offers one request from the falling edge on and holds it until the
   // block accepts it; the model then records the expected response.
   task automatic send_req(input req_type item, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      @(negedge clock);
      req_valid = 1'b1;
      req_data = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = pool_predict(item);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // Stops offering requests, waits for every outstanding response and lets
   // the slowest possible transaction finish before going on.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pool_size(input logic [CFG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool_cfg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // The receiver alternates between stretches of steady acceptance, random
   // stalls and a fixed stall pattern. On request it holds off for a long
   // stretch so the block fills up and pushes back on the request channel.
   initial begin : rsp_pacer
      int unsigned span;
      int unsigned mode;
      int unsigned k;
      rsp_ready = 1'b0;
      forever begin
         if (rsp_hold_asked) begin
            rsp_hold_asked = 1'b0;
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 60);
            for (k = 0; k < span; k++) begin
               @(negedge clock);
               case (mode)
                  0: rsp_ready = 1'b1;
                  1: rsp_ready = 1'($urandom_range(0, 1));
                  default: rsp_ready = (k % 7) < 4;
               endcase
            end
         end
      end
   end

   // Every completed response transaction is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            log_error($sformatf("response %0d with nothing expected: item %0d status %0d remaining %0d",
                                rsp_seen, rsp_data.picked_item, rsp_data.status,
                                rsp_data.remaining_after));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.picked_item !== want.picked_item || rsp_data.status !== want.status ||
                rsp_data.remaining_after !== want.remaining_after) begin
               log_error($sformatf({"response %0d: expected item %0d status %0d remaining %0d,",
                                    " got item %0d status %0d remaining %0d"},
                                   rsp_seen, want.picked_item, want.status,
                                   want.remaining_after, rsp_data.picked_item, rsp_data.status,
                                   rsp_data.remaining_after));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL pick_without_replacement_pool_top");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      int unsigned      idx;
      int unsigned      phase;
      int unsigned      sent;
      int unsigned      burst;
      int unsigned      gap;
      int unsigned      k;
      logic [CFG_W-1:0] phase_cfg;

      // After reset the store holds the identity order and the pool is full.
      for (idx = 0; idx < POOL_DEPTH; idx++) pool_items[idx] = ITEM_W'(idx);
      pool_cfg = POOL_SIZE_RESET;
      left_count = REMAIN_W'(POOL_SIZE_RESET);

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;

      // Directed table. The first rows walk the store by hand: picks at both
      // ends, a value search that must skip an item already picked, then the
      // extremes of the random word and the spare operation codes.
      plan.push_back(req_row(OP_RESTORE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd64));
      plan.push_back(req_row(OP_POS, 6'd63, 32'd0, 6'd0, 1'b1, 6'd63, ST_OK, 7'd63));
      plan.push_back(req_row(OP_POS, 6'd63, 32'd0, 6'd0, 1'b1, 6'd0, ST_MISS, 7'd63));
      plan.push_back(req_row(OP_POS, 6'd0, 32'hFFFF_FFFF, 6'd63, 1'b1, 6'd0, ST_OK, 7'd62));
      plan.push_back(req_row(OP_VALUE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_MISS, 7'd62));
      plan.push_back(req_row(OP_VALUE, 6'd63, 32'd0, 6'd62, 1'b1, 6'd62, ST_OK, 7'd61));
      plan.push_back(req_row(OP_RANDOM, 6'd0, 32'hFFFF_FFFF, 6'd0, 1'b0, '0, ST_OK, '0));
      plan.push_back(req_row(OP_RANDOM, 6'd63, 32'd0, 6'd63, 1'b0, '0, ST_OK, '0));
      plan.push_back(req_row(OP_SPARE_LO, 6'd63, 32'hFFFF_FFFF, 6'd63, 1'b0, '0, ST_OK, '0));
      plan.push_back(req_row(OP_SPARE_MID, 6'd21, 32'hA5A5_5A5A, 6'd42, 1'b0, '0, ST_OK, '0));
      plan.push_back(req_row(OP_SPARE_HI, 6'd0, 32'd0, 6'd0, 1'b0, '0, ST_OK, '0));
      plan.push_back(req_row(OP_FILL, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd64));
      // A pool size of zero leaves the pool empty after fill and restore.
      plan.push_back(csr_row(7'd0));
      plan.push_back(req_row(OP_RESTORE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd0));
      plan.push_back(req_row(OP_POS, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_MISS, 7'd0));
      plan.push_back(req_row(OP_RANDOM, 6'd0, 32'd12345, 6'd0, 1'b1, 6'd0, ST_EMPTY, 7'd0));
      plan.push_back(req_row(OP_VALUE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_MISS, 7'd0));
      plan.push_back(req_row(OP_FILL, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd0));
      // A pool size above the store depth is clipped to the depth.
      plan.push_back(csr_row(7'd127));
      plan.push_back(req_row(OP_RESTORE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd64));
      // A single-item pool: one pick empties it.
      plan.push_back(csr_row(7'd1));
      plan.push_back(req_row(OP_FILL, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd1));
      plan.push_back(req_row(OP_RANDOM, 6'd0, 32'hFFFF_FFFF, 6'd0, 1'b1, 6'd0, ST_OK, 7'd0));
      plan.push_back(req_row(OP_RANDOM, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_EMPTY, 7'd0));
      plan.push_back(req_row(OP_RESTORE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd1));
      plan.push_back(req_row(OP_VALUE, 6'd0, 32'd0, 6'd63, 1'b1, 6'd0, ST_MISS, 7'd1));
      plan.push_back(req_row(OP_VALUE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd0));
      plan.push_back(csr_row(7'd64));
      plan.push_back(req_row(OP_RESTORE, 6'd0, 32'd0, 6'd0, 1'b1, 6'd0, ST_OK, 7'd64));
      plan.push_back(req_row(OP_VALUE, 6'd0, 32'd0, 6'd63, 1'b1, 6'd63, ST_OK, 7'd63));

      // Synchronous reset; the block then runs its own identity pass with
      // req_ready low, which the request handshake simply waits out.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (idx = 0; idx < plan.size(); idx++) begin
         if (plan[idx].kind == ROW_CSR) write_pool_size(plan[idx].cfg_value);
         else send_req(plan[idx].item, plan[idx].typed, plan[idx].rsp);
      end

      // Random phases, each under its own pool size. Every phase starts with
      // the request side paused until all responses are in, since pool_size
      // is only rewritten while the block is idle.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: phase_cfg = 7'd64;
            1: phase_cfg = 7'd5;
            2: phase_cfg = 7'd127;
            3: phase_cfg = 7'd1;
            4: phase_cfg = CFG_W'($urandom_range(2, 63));
            default: phase_cfg = 7'd64;
         endcase
         write_pool_size(phase_cfg);
         // The first phase also gets the long receiver hold-off while the
         // sender keeps offering requests.
         if (phase == 0) rsp_hold_asked = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 20);
            for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               send_req(next_request(), 1'b0, '0);
               sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               @(negedge clock);
               req_valid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end

      wait_idle();
      if (expected_rsp.size() != 0) begin
         log_error($sformatf("%0d expected responses never arrived", expected_rsp.size()));
      end

      if (error_count == 0) begin
         $display("PASS pick_without_replacement_pool_top");
      end else begin
         $display("FAIL pick_without_replacement_pool_top");
      end
      $finish;
   end

endmodule
